// File: rtl/core/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
`timescale 1ns / 1ps

package lkv_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int DATA_W = 32;
   localparam int CFG_W = 5;
   localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;
   localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

   localparam int ITEM_QUEUE_DEPTH = 2;
   localparam int RESULT_QUEUE_DEPTH = 4;
   localparam int RESULT_COUNT_W = $clog2(RESULT_QUEUE_DEPTH + 1);

   typedef enum logic [0:0] {
      OP_GET = 1'b0,
      OP_SET = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      ST_LOOKUP = 1'b0,
      ST_APPLY  = 1'b1
   } state_type;

   typedef struct packed {
      op_type op;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] value;
   } item_type;

   typedef struct packed {
      logic hit;
      logic signed [DATA_W-1:0] read_value;
   } result_type;

endpackage

// File: rtl/core/lkv_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module lkv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/lkv_fifo.sv
// Small first-in first-out queue with a visible head entry.
`timescale 1ns / 1ps

module lkv_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             full,
   output logic             empty,
   output logic [CNT_W-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata = slot_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

// File: rtl/core/lkv_front.sv
// Front end: takes request items, decodes the operation and feeds the work queue.
`timescale 1ns / 1ps

module lkv_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic                               req_mode,
   input  logic signed [lkv_pkg::DATA_W-1:0]  req_key,
   input  logic signed [lkv_pkg::DATA_W-1:0]  req_value,
   output logic                               queue_push,
   output lkv_pkg::item_type                  queue_item,
   input  logic                               queue_full
);

   logic              hold_valid_ff, hold_valid_in;
   lkv_pkg::item_type hold_ff;
   logic              accept;

   // The holding register drains into the queue in the same cycle a new item lands.
   assign req_full   = hold_valid_ff && queue_full;
   assign accept     = req_push && !req_full;
   assign queue_push = hold_valid_ff && !queue_full;
   assign queue_item = hold_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (queue_push) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff.op    <= lkv_pkg::op_type'(req_mode);
         hold_ff.key   <= req_key;
         hold_ff.value <= req_value;
      end
   end

endmodule

// File: rtl/core/lkv_back.sv
// Back end: cell array with key match, recency ranks and the value memory.
`timescale 1ns / 1ps

module lkv_back #(
   parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [lkv_pkg::CFG_W-1:0]           csr_wdata,
   input  logic                                queue_empty,
   input  lkv_pkg::item_type                   queue_item,
   output logic                                queue_pop,
   input  logic [lkv_pkg::RESULT_COUNT_W-1:0]  result_count,
   output logic                                result_push,
   output lkv_pkg::result_type                 result
);

   localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W  = (OCC_W > lkv_pkg::CFG_W) ? OCC_W : lkv_pkg::CFG_W;
   localparam int RC_W   = lkv_pkg::RESULT_COUNT_W + 1;

   lkv_pkg::state_type state_ff, state_in;

   logic [lkv_pkg::CFG_W-1:0]  cap_ff;
   logic [MAX_ENTRIES-1:0]     valid_ff, valid_in;
   logic [lkv_pkg::DATA_W-1:0] key_ff [MAX_ENTRIES];
   logic [lkv_pkg::DATA_W-1:0] key_in [MAX_ENTRIES];
   logic [RANK_W-1:0]          rank_ff [MAX_ENTRIES];
   logic [RANK_W-1:0]          rank_in [MAX_ENTRIES];
   logic [OCC_W-1:0]           occ_ff, occ_in;

   lkv_pkg::item_type          cur_ff;
   logic [MAX_ENTRIES-1:0]     tgt_oh_ff, tgt_oh_in;
   logic [RANK_W-1:0]          limit_ff, limit_in;
   logic                       hit_ff, hit_in;
   logic                       insert_ff, insert_in;
   logic                       pend_ff, pend_hit_ff;

   logic                       start, applying;
   logic [MAX_ENTRIES-1:0]     match, lru, free_vec, free_oh;
   logic                       any_hit, evict;
   logic [CMP_W-1:0]           cap_ext, eff_cap;
   logic [RANK_W-1:0]          tgt_rank;
   logic [IDX_W-1:0]           tgt_idx;
   logic [lkv_pkg::DATA_W-1:0] ram_rdata;
   logic                       ram_we;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lkv_pkg::ST_LOOKUP: begin
            if (start) begin
               state_in = lkv_pkg::ST_APPLY;
            end
         end
         lkv_pkg::ST_APPLY: begin
            state_in = lkv_pkg::ST_LOOKUP;
         end
         default: begin
            state_in = lkv_pkg::ST_LOOKUP;
         end
      endcase
   end

   // A new item starts only when the result queue can take every pending answer.
   always_comb begin
      start    = 1'b0;
      applying = 1'b0;
      case (state_ff)
         lkv_pkg::ST_LOOKUP: begin
            start = !queue_empty &&
                    ((RC_W'(result_count) + RC_W'(pend_ff)) <
                     RC_W'(lkv_pkg::RESULT_QUEUE_DEPTH));
         end
         lkv_pkg::ST_APPLY: begin
            applying = 1'b1;
         end
         default: begin
            start    = 1'b0;
            applying = 1'b0;
         end
      endcase
   end

   assign queue_pop = start;

   // Lookup: match every cell against the head key, find the oldest and a free cell.
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == queue_item.key);
         lru[i]   = valid_ff[i] && (rank_ff[i] == RANK_W'(occ_ff - 1'b1));
      end
      any_hit  = |match;
      free_vec = ~valid_ff;
      free_oh  = free_vec & (~free_vec + 1'b1);
      cap_ext  = CMP_W'(cap_ff);
      if (cap_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
         eff_cap = CMP_W'(MAX_ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
      evict = CMP_W'(occ_ff) >= eff_cap;

      if (any_hit) begin
         tgt_oh_in = match;
      end else if (evict) begin
         tgt_oh_in = lru;
      end else begin
         tgt_oh_in = free_oh;
      end

      tgt_rank = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (tgt_oh_in[i]) begin
            tgt_rank = tgt_rank | rank_ff[i];
         end
      end

      hit_in = any_hit;
      // Filling a free cell ages every valid cell, as if the new one had rank occupancy.
      insert_in = !any_hit && !evict && (queue_item.op == lkv_pkg::OP_SET);
      limit_in  = (!any_hit && !evict) ? RANK_W'(occ_ff) : tgt_rank;
   end

   // Apply: on a hit or a set, promote the target cell and age every valid cell that was more recent.
   always_comb begin
      logic update;
      update   = hit_ff || (cur_ff.op == lkv_pkg::OP_SET);
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         key_in[i]  = key_ff[i];
         rank_in[i] = rank_ff[i];
         if (applying && update) begin
            if (tgt_oh_ff[i]) begin
               rank_in[i] = '0;
               if (!hit_ff) begin
                  key_in[i]   = cur_ff.key;
                  valid_in[i] = 1'b1;
               end
            end else if (valid_ff[i] && (rank_ff[i] < limit_ff)) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
      end
      if (applying && insert_ff) begin
         occ_in = occ_ff + 1'b1;
      end
   end

   always_comb begin
      tgt_idx = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (tgt_oh_ff[i]) begin
            tgt_idx = tgt_idx | IDX_W'(i);
         end
      end
   end

   assign ram_we = applying && (cur_ff.op == lkv_pkg::OP_SET);

   lkv_ram #(
      .WIDTH (lkv_pkg::DATA_W),
      .DEPTH (MAX_ENTRIES)
   ) u_value_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (tgt_idx),
      .wdata (cur_ff.value),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lkv_pkg::ST_LOOKUP;
         cap_ff   <= lkv_pkg::CAP_RESET;
         valid_ff <= '0;
         occ_ff   <= '0;
         pend_ff  <= 1'b0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         pend_ff  <= applying && (cur_ff.op == lkv_pkg::OP_GET);
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         key_ff[i] <= key_in[i];
      end
      pend_hit_ff <= hit_ff;
      if (start) begin
         cur_ff    <= queue_item;
         tgt_oh_ff <= tgt_oh_in;
         limit_ff  <= limit_in;
         hit_ff    <= hit_in;
         insert_ff <= insert_in;
      end
   end

   assign result_push       = pend_ff;
   assign result.hit        = pend_hit_ff;
   assign result.read_value = pend_hit_ff ? ram_rdata : lkv_pkg::MISS_VALUE;

endmodule

// File: rtl/core/lru_key_value_cache.sv
// Top level of the fully associative key-value cache with LRU replacement.
//
//   channel  direction  handshake            payload
//   req      in         req_push / req_full  req_mode, req_key, req_value
//   rsp      out        rsp_pop / rsp_empty  rsp_hit, rsp_read_value
//   csr      in         csr_we               csr_wdata (capacity in use)
//
// Each item passes through the back end in the LOOKUP state, which compares the key against
// every cell and picks the target, then in the APPLY state, which updates the ranks and accesses the value RAM.
// A get's result goes from the holding register through the work queue, both back-end states
// and the registered RAM read into the result queue before it shows on the result ports.
// Reset is synchronous and clears the cells directly; there is no clearing pass.
// A full result queue stalls the back end; the work queue lets the front keep taking items until it fills.
`timescale 1ns / 1ps

module lru_key_value_cache #(
   parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic                               req_mode,
   input  logic signed [lkv_pkg::DATA_W-1:0]  req_key,
   input  logic signed [lkv_pkg::DATA_W-1:0]  req_value,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic                               rsp_hit,
   output logic signed [lkv_pkg::DATA_W-1:0]  rsp_read_value,
   input  logic                               csr_we,
   input  logic [lkv_pkg::CFG_W-1:0]          csr_wdata
);

   localparam int ITEM_CNT_W = $clog2(lkv_pkg::ITEM_QUEUE_DEPTH + 1);

   logic                               wq_push, wq_pop, wq_full, wq_empty;
   lkv_pkg::item_type                  wq_wdata, wq_rdata;
   logic [ITEM_CNT_W-1:0]              wq_count;
   logic                               rq_push, rq_full;
   lkv_pkg::result_type                rq_wdata, rq_rdata;
   logic [lkv_pkg::RESULT_COUNT_W-1:0] rq_count;

   lkv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_mode   (req_mode),
      .req_key    (req_key),
      .req_value  (req_value),
      .queue_push (wq_push),
      .queue_item (wq_wdata),
      .queue_full (wq_full)
   );

   lkv_fifo #(
      .WIDTH ($bits(lkv_pkg::item_type)),
      .DEPTH (lkv_pkg::ITEM_QUEUE_DEPTH)
   ) u_work_queue (
      .clock (clock),
      .reset (reset),
      .push  (wq_push),
      .wdata (wq_wdata),
      .pop   (wq_pop),
      .rdata (wq_rdata),
      .full  (wq_full),
      .empty (wq_empty),
      .count (wq_count)
   );

   lkv_back #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .queue_empty  (wq_empty),
      .queue_item   (wq_rdata),
      .queue_pop    (wq_pop),
      .result_count (rq_count),
      .result_push  (rq_push),
      .result       (rq_wdata)
   );

   lkv_fifo #(
      .WIDTH ($bits(lkv_pkg::result_type)),
      .DEPTH (lkv_pkg::RESULT_QUEUE_DEPTH)
   ) u_result_queue (
      .clock (clock),
      .reset (reset),
      .push  (rq_push),
      .wdata (rq_wdata),
      .pop   (rsp_pop),
      .rdata (rq_rdata),
      .full  (rq_full),
      .empty (rsp_empty),
      .count (rq_count)
   );

   // The back end reserves room before it starts an item, so the result queue never
   // sees a push while full; the full flag only feeds a guard on rsp_hit that can never fire.
   assign rsp_hit        = rq_rdata.hit && !(rq_full && rq_push && rsp_empty);
   assign rsp_read_value = rq_rdata.read_value;

endmodule

// File: rtl/core/lkv_checker.sv
// Port-level checks for the LRU key-value cache, bound to the top level.
`timescale 1ns / 1ps

module lkv_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_full,
   input logic                               rsp_empty,
   input logic                               rsp_pop,
   input logic                               rsp_hit,
   input logic signed [lkv_pkg::DATA_W-1:0]  rsp_read_value
);

   // Out of reset nothing is waiting and the input side is open.
   assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("cache not empty and open after reset");

   // A miss always reports the miss value.
   assert property (@(posedge clock) disable iff (reset)
                    !rsp_empty && !rsp_hit |-> rsp_read_value == lkv_pkg::MISS_VALUE)
      else $error("miss result with a value other than the miss value");

   // A waiting result holds until it is taken.
   assert property (@(posedge clock) disable iff (reset)
                    !rsp_empty && !rsp_pop |=>
                    !rsp_empty && $stable(rsp_hit) && $stable(rsp_read_value))
      else $error("waiting result changed before it was taken");

   // No result can show up right after reset, since an item must first pass through the
   // holding register, the work queue, the back end and the result queue.
   assert property (@(posedge clock) reset |=> rsp_empty [*4])
      else $error("result appeared too soon after reset");

endmodule

bind lru_key_value_cache lkv_checker u_checker (.*);
